@@ rtl/unsigned_to_decimal_ascii_top_defines.svh @@
// Assertion macros shared by the converter modules.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Checked only out of reset.
`define UTDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UTDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/utda_pkg.sv @@
// Shared constants, types and helpers of the decimal ASCII converter.
package utda_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int VALUE_BITS      = 64;
  localparam int CHAR_WIDTH      = 6;
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

  // Decimal digits needed for 2**w - 1: floor(w * log10(2)) + 1.
  function automatic int digit_count(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/utda_front.sv @@
// Front end: accepts an item and converts it to BCD by serial double dabble.
module utda_front #(
  parameter int VALUE_WIDTH = utda_pkg::VALUE_WIDTH_DEF,
  parameter int NDIG        = utda_pkg::digit_count(VALUE_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [utda_pkg::VALUE_BITS-1:0]  value,
  output logic                             busy,
  input  utda_pkg::fifo_stat_t             fifo_stat,
  output logic                             push,
  output logic [NDIG*4-1:0]                push_data
);

  localparam int BW = NDIG * 4;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] binv;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          adj;

  always_comb begin
    adj = bcd;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CONV;
            cnt   <= '0;
          end
        end
        S_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(VALUE_WIDTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!fifo_stat.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      binv <= value[VALUE_WIDTH-1:0];
      bcd  <= '0;
    end else if (state == S_CONV) begin
      binv <= {binv[VALUE_WIDTH-2:0], 1'b0};
      bcd  <= {adj[BW-2:0], binv[VALUE_WIDTH-1]};
    end
  end

  assign busy      = (state != S_IDLE);
  assign push      = (state == S_DONE) && !fifo_stat.full;
  assign push_data = bcd;

endmodule

@@ rtl/utda_fifo.sv @@
// Two-entry item queue between the converter and the digit emitter.
`include "unsigned_to_decimal_ascii_top_defines.svh"

module utda_fifo #(
  parameter int DATA_W = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_W-1:0]    push_data,
  input  logic                 pop,
  output logic [DATA_W-1:0]    pop_data,
  output utda_pkg::fifo_stat_t stat
);

  logic [DATA_W-1:0] entry [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  assign pop_data   = entry[rptr];
  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);

  `UTDA_ASSERT(a_no_overflow, push |-> !stat.full, "push into full queue")
  `UTDA_ASSERT(a_no_underflow, pop |-> !stat.empty, "pop from empty queue")
  `UTDA_ASSERT(a_cnt_range, cnt != 2'd3, "queue count out of range")

endmodule

@@ rtl/utda_back.sv @@
// Back end: walks BCD digits from the top, drops leading zeros, emits ASCII.
`include "unsigned_to_decimal_ascii_top_defines.svh"

module utda_back #(
  parameter int NDIG = utda_pkg::digit_count(utda_pkg::VALUE_WIDTH_DEF)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  utda_pkg::fifo_stat_t              fifo_stat,
  input  logic [NDIG*4-1:0]                 pop_data,
  output logic                              pop,
  output logic                              strobe,
  output logic [utda_pkg::CHAR_WIDTH-1:0]   digit_char,
  output logic                              last_digit
);

  localparam int BW = NDIG * 4;
  localparam int IW = $clog2(NDIG);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic          state;
  logic [IW-1:0] idx;
  logic          seen;
  logic [BW-1:0] shreg;
  logic [3:0]    top;
  logic          is_last;
  logic          emit;

  assign top     = shreg[BW-1 -: 4];
  assign is_last = (idx == '0);
  assign emit    = seen || (top != 4'd0) || is_last;
  assign pop     = (state == S_IDLE) && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      idx    <= '0;
      seen   <= 1'b0;
    end else begin
      strobe <= (state == S_RUN) && emit;
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_RUN;
            idx   <= IW'(NDIG - 1);
            seen  <= 1'b0;
          end
        end
        S_RUN: begin
          idx  <= idx - 1'b1;
          seen <= seen || (top != 4'd0);
          if (is_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= pop_data;
    end else if (state == S_RUN) begin
      shreg <= {shreg[BW-5:0], 4'd0};
    end
    digit_char <= utda_pkg::ASCII_ZERO + {2'b00, top};
    last_digit <= is_last;
  end

  `UTDA_ASSERT(a_char_range, strobe |-> (digit_char >= 6'd48 && digit_char <= 6'd57),
    "digit out of range")
  `UTDA_ASSERT(a_gap_after_last, (strobe && last_digit) |=> !strobe,
    "digit right after last digit")

endmodule

@@ rtl/unsigned_to_decimal_ascii_top.sv @@
// Top level of the unsigned binary to decimal ASCII converter.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+--------------------------------
//  input   | value                         | start high while busy is low
//  result  | digit_char, last_digit        | strobe, one cycle, no stall
//
// An item passes through the serial double dabble loop, one input bit per cycle,
// and then enters the queue; busy is high throughout, so a new item is taken only
// once the previous one has left the front end. The digit side walks all NDIG
// digits of an item while the next item converts; busy also holds while the
// two-entry queue is full, which the faster digit side never lets happen.
// The receiver cannot stall.
// Reset is synchronous and clears all control state.
module unsigned_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = utda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [utda_pkg::VALUE_BITS-1:0]  value,
  output logic                             busy,
  output logic                             strobe,
  output logic [utda_pkg::CHAR_WIDTH-1:0]  digit_char,
  output logic                             last_digit
);

  localparam int NDIG = utda_pkg::digit_count(VALUE_WIDTH);

  utda_pkg::fifo_stat_t fifo_stat;
  logic                 push;
  logic                 pop;
  logic [NDIG*4-1:0]    push_data;
  logic [NDIG*4-1:0]    pop_data;

  utda_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NDIG(NDIG)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .busy(busy),
    .fifo_stat(fifo_stat),
    .push(push),
    .push_data(push_data)
  );

  utda_fifo #(
    .DATA_W(NDIG * 4)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .pop_data(pop_data),
    .stat(fifo_stat)
  );

  utda_back #(
    .NDIG(NDIG)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .fifo_stat(fifo_stat),
    .pop_data(pop_data),
    .pop(pop),
    .strobe(strobe),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

endmodule

@@ tb/unsigned_to_decimal_ascii_top_tb.sv @@
// Testbench for the decimal ASCII converter: random and directed numbers, per-digit check.
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_top_tb;

  localparam int MAX_DIGITS  = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    logic [utda_pkg::VALUE_BITS-1:0] num;
    int                              idle_pct;
    bit                              drain_first;
  } num_item_t;

  typedef struct {
    logic [utda_pkg::CHAR_WIDTH-1:0] ch;
    logic                            last;
  } digit_exp_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic [utda_pkg::VALUE_BITS-1:0] value = '0;
  logic                            busy;
  logic                            strobe;
  logic [utda_pkg::CHAR_WIDTH-1:0] digit_char;
  logic                            last_digit;

  num_item_t  pending_items[$];
  digit_exp_t expected_digits[$];
  digit_exp_t want;
  digit_exp_t none_waiting;
  bit         item_taken = 1'b0;
  int         quiet_cycles = 0;
  int         error_count = 0;

  unsigned_to_decimal_ascii_top DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .busy       (busy),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decimal digits of num, most significant first, into the expected store.
  function automatic void predict_decimal_digits(
      input logic [utda_pkg::VALUE_BITS-1:0] num);
    logic [3:0]                      rev [MAX_DIGITS];
    logic [utda_pkg::VALUE_BITS-1:0] rest;
    int                              n;
    digit_exp_t                      e;
    rest = num;
    n = 0;
    do begin
      rev[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      e.ch = utda_pkg::ASCII_ZERO + {2'b00, rev[k]};
      e.last = (k == 0);
      expected_digits.push_back(e);
    end
  endfunction

  function automatic logic [utda_pkg::VALUE_BITS-1:0] rand_value();
    logic [utda_pkg::VALUE_BITS-1:0] v;
    logic [utda_pkg::VALUE_BITS-1:0] p;
    int                              k;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = v;
      1: v = v >> $urandom_range(63);
      2: begin
        p = 1;
        k = $urandom_range(MAX_DIGITS - 1);
        repeat (k) p = p * 10;
        v = p + $urandom_range(2) - 1;
      end
      default: v = $urandom_range(99);
    endcase
    return v;
  endfunction

  task automatic queue_number(input logic [utda_pkg::VALUE_BITS-1:0] num, input int pct,
                              input bit drain);
    num_item_t it;
    it.num = num;
    it.idle_pct = pct;
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  task automatic flag_digit(input string what, input digit_exp_t exp_d);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected char %0d last %0d, got char %0d last %0d", $realtime,
               what, exp_d.ch, exp_d.last, digit_char, last_digit);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      value <= '0;
    end else if (!start || item_taken) begin
      if (pending_items.size() != 0
          && !(pending_items[0].drain_first && expected_digits.size() != 0)
          && $urandom_range(99) >= pending_items[0].idle_pct) begin
        start <= 1'b1;
        value <= pending_items.pop_front().num;
      end else begin
        start <= 1'b0;
        value <= {$urandom, $urandom};
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      item_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      item_taken = start && !busy;
      if (item_taken)
        predict_decimal_digits(value);
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          flag_digit("unexpected digit", none_waiting);
        end else begin
          want = expected_digits.pop_front();
          if (want.ch != digit_char || want.last != last_digit)
            flag_digit("digit mismatch", want);
        end
      end
      if (item_taken || strobe)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int pct [4];
    none_waiting.ch = '0;
    none_waiting.last = 1'b0;
    pct[0] = 0;
    pct[1] = 67;
    pct[2] = 0;
    pct[3] = 29;

    queue_number(64'd0, 0, 1'b0);
    queue_number(64'd1, 0, 1'b0);
    queue_number(64'd9, 0, 1'b0);
    queue_number(64'd10, 0, 1'b0);
    queue_number(64'd99, 0, 1'b0);
    queue_number(64'd100, 0, 1'b0);
    queue_number(64'd255, 0, 1'b0);
    queue_number(64'd256, 0, 1'b0);
    queue_number(64'd65535, 0, 1'b0);
    queue_number(64'd4294967295, 0, 1'b0);
    queue_number(64'd4294967296, 0, 1'b0);
    queue_number(64'd9999999999999999999, 0, 1'b0);
    queue_number(64'd10000000000000000000, 0, 1'b0);
    queue_number(64'd12345678901234567890, 0, 1'b0);
    queue_number(64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
    queue_number(64'h8000_0000_0000_0000, 0, 1'b0);
    queue_number(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    queue_number(64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);
    queue_number(64'h5555_5555_5555_5555, 0, 1'b0);
    queue_number(64'd0, 0, 1'b0);
    queue_number(64'd18446744073709551610, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++)
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_number(rand_value(), pct[ph], i == 0);

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_items.size() != 0 || start) @(negedge clk);
    while (expected_digits.size() != 0) @(negedge clk);
    repeat (utda_pkg::VALUE_BITS + 2 * MAX_DIGITS + 10) @(negedge clk);

    if (error_count == 0 && expected_digits.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/utda_pkg.sv
rtl/utda_front.sv
rtl/utda_fifo.sv
rtl/utda_back.sv
rtl/unsigned_to_decimal_ascii_top.sv
tb/unsigned_to_decimal_ascii_top_tb.sv
